// ===== hw/rtl/btlv_pkg.sv =====
// Shared types and constants for the BER-TLV stream decoder.
// Holds the decode phases, the result kinds and the result record.
// No dependencies.
`timescale 1ns / 1ps

package btlv_pkg;

   localparam int unsigned LEN_BYTES_MAX = 4;
   localparam int unsigned LEN_CNT_W     = 3;

   localparam logic [7:0] TAG_LONG_MASK = 8'h1f;
   localparam logic [7:0] PAD_BYTE      = 8'hff;

   typedef enum logic [2:0] {
      PH_TAG1  = 3'd0,
      PH_TAG2  = 3'd1,
      PH_TAG3  = 3'd2,
      PH_LEN1  = 3'd3,
      PH_LENX  = 3'd4,
      PH_VALUE = 3'd5,
      PH_SKIP  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_CLEAN  = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  tag_class;
      logic        is_constructed;
      logic [14:0] tag_number;
      logic [23:0] tag_raw;
      logic [31:0] value_length;
      logic [7:0]  value_byte;
      logic        element_end;
      logic        last_result;
   } result_type;

   typedef struct packed {
      result_type  first;
      result_type  second;
      logic [1:0]  count;
   } step_type;

endpackage

// ===== hw/rtl/btlv_decode.sv =====
// Decode state and per-word next-state logic of the BER-TLV stream decoder.
// Produces up to two results for the word held in the input register.
// Depends on btlv_pkg.
`timescale 1ns / 1ps

module btlv_parse
   import btlv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] data_byte,
   input  logic       buffer_end,
   output step_type   step
);

   phase_type             phase_ff, phase_in;
   logic [1:0]            class_ff, class_in;
   logic                  cons_ff, cons_in;
   logic [14:0]           tag_num_ff, tag_num_in;
   logic [23:0]           tag_raw_ff, tag_raw_in;
   logic [LEN_CNT_W-1:0]  len_left_ff, len_left_in;
   logic [31:0]           length_ff, length_in;
   logic [31:0]           val_left_ff, val_left_in;
   logic                  pad_ff, pad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG1;
         pad_ff   <= 1'b1;
      end else if (advance) begin
         phase_ff <= phase_in;
         pad_ff   <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         class_ff    <= class_in;
         cons_ff     <= cons_in;
         tag_num_ff  <= tag_num_in;
         tag_raw_ff  <= tag_raw_in;
         len_left_ff <= len_left_in;
         length_ff   <= length_in;
         val_left_ff <= val_left_in;
      end
   end

   always_comb begin
      logic        is_pad;
      logic        hdr;
      logic        main;
      logic [6:0]  nb;
      result_type  main_res;
      result_type  end_res;
      kind_type    end_kind;

      is_pad      = (data_byte == PAD_BYTE);
      hdr         = 1'b0;
      main        = 1'b0;
      nb          = data_byte[6:0];
      phase_in    = phase_ff;
      class_in    = class_ff;
      cons_in     = cons_ff;
      tag_num_in  = tag_num_ff;
      tag_raw_in  = tag_raw_ff;
      len_left_in = len_left_ff;
      length_in   = length_ff;
      val_left_in = val_left_ff;
      pad_in      = pad_ff;
      main_res    = '0;
      end_res     = '0;

      if (phase_ff != PH_TAG1 && phase_ff != PH_VALUE) begin
         pad_in = pad_ff & is_pad;
      end

      unique case (phase_ff)
         PH_TAG1: begin
            pad_in     = is_pad;
            class_in   = data_byte[7:6];
            cons_in    = data_byte[5];
            tag_raw_in = {16'd0, data_byte};
            length_in  = '0;
            if ((data_byte & TAG_LONG_MASK) == TAG_LONG_MASK) begin
               tag_num_in = '0;
               phase_in   = PH_TAG2;
            end else begin
               tag_num_in = {10'd0, data_byte[4:0]};
               phase_in   = PH_LEN1;
            end
         end
         PH_TAG2: begin
            tag_raw_in = {tag_raw_ff[15:0], data_byte};
            tag_num_in = {8'd0, data_byte[6:0]};
            phase_in   = data_byte[7] ? PH_TAG3 : PH_LEN1;
         end
         PH_TAG3: begin
            tag_raw_in = {tag_raw_ff[15:0], data_byte};
            tag_num_in = {tag_num_ff[6:0], data_byte};
            phase_in   = PH_LEN1;
         end
         PH_LEN1: begin
            if (!data_byte[7]) begin
               length_in = {24'd0, data_byte};
               hdr       = 1'b1;
            end else if (nb == 7'd0 || nb > 7'(LEN_BYTES_MAX)) begin
               phase_in = PH_SKIP;
            end else begin
               len_left_in = nb[LEN_CNT_W-1:0];
               length_in   = '0;
               phase_in    = PH_LENX;
            end
         end
         PH_LENX: begin
            length_in = {length_ff[23:0], data_byte};
            if (len_left_ff != '0) begin
               len_left_in = len_left_ff - 1'b1;
            end
            if (len_left_in == '0) begin
               hdr = 1'b1;
            end
         end
         PH_VALUE: begin
            main                 = 1'b1;
            main_res.kind        = KIND_VALUE;
            main_res.value_byte  = data_byte;
            main_res.element_end = (val_left_ff[31:1] == '0);
            if (val_left_ff != '0) begin
               val_left_in = val_left_ff - 1'b1;
            end
            if (val_left_in == '0) begin
               phase_in = PH_TAG1;
            end
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      if (hdr) begin
         main                 = 1'b1;
         main_res.kind        = KIND_HEADER;
         main_res.element_end = (length_in == '0);
         if (length_in == '0) begin
            phase_in = PH_TAG1;
         end else begin
            val_left_in = length_in;
            phase_in    = PH_VALUE;
         end
      end

      main_res.tag_class      = class_in;
      main_res.is_constructed = cons_in;
      main_res.tag_number     = tag_num_in;
      main_res.tag_raw        = tag_raw_in;
      main_res.value_length   = length_in;
      main_res.last_result    = !buffer_end;

      if (phase_in == PH_TAG1) begin
         end_kind = KIND_CLEAN;
      end else if (phase_in == PH_VALUE) begin
         end_kind = KIND_ERROR;
      end else begin
         end_kind = pad_in ? KIND_CLEAN : KIND_ERROR;
      end
      end_res.kind        = end_kind;
      end_res.last_result = 1'b1;

      if (buffer_end) begin
         phase_in = PH_TAG1;
         pad_in   = 1'b1;
      end

      step = '0;
      if (main) begin
         step.first  = main_res;
         step.second = end_res;
         step.count  = buffer_end ? 2'd2 : 2'd1;
      end else if (buffer_end) begin
         step.first  = end_res;
         step.count  = 2'd1;
      end
   end

endmodule

// ===== hw/rtl/btlv_result_queue.sv =====
// Two-entry result queue of the BER-TLV stream decoder.
// Takes up to two results per cycle and drives one result word out.
// Depends on btlv_pkg.
`timescale 1ns / 1ps

module btlv_result_queue
   import btlv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  step_type   step,
   input  logic       pop,
   output logic [1:0] fill,
   output logic       head_valid,
   output result_type head
);

   result_type entry_ff [2];
   result_type entry_in [2];
   logic [1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

   always_comb begin
      logic [1:0] base;
      logic [1:0] added;

      base        = count_ff - {1'b0, pop};
      added       = push ? step.count : 2'd0;
      entry_in[0] = pop ? entry_ff[1] : entry_ff[0];
      entry_in[1] = entry_ff[1];

      case (base)
         2'd0: begin
            if (added != 2'd0) begin
               entry_in[0] = step.first;
            end
            if (added == 2'd2) begin
               entry_in[1] = step.second;
            end
         end
         2'd1: begin
            if (added != 2'd0) begin
               entry_in[1] = step.first;
            end
         end
         default: begin
         end
      endcase

      count_in = base + added;
   end

   assign fill       = count_ff;
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[0];

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue over capacity");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1 && pop && !push) |=> (count_ff == 2'd0))
      else $error("result queue did not drain");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (head_valid && (head.kind == KIND_CLEAN || head.kind == KIND_ERROR))
         |-> head.last_result)
      else $error("buffer end result without last flag");

endmodule

// ===== hw/rtl/ber_tlv_stream_decoder_core.sv =====
// Top level of the BER-TLV stream decoder: input register, decode, result queue.
// Depends on btlv_pkg, btlv_parse and btlv_result_queue.
//
// Takes one encoded byte per word on req and returns header, value-byte and
// buffer-end results on rsp, one result per word; each byte is held in the input
// register and its results are written into the result queue, which drives rsp.
// A byte is accepted every cycle while results keep draining; a byte that
// causes two results (a header or value byte on the final byte of the buffer,
// plus its clean-end or error result) fills both entries of the two-entry
// result queue, which drains one result per cycle while rsp_tready is high. A
// decode-error result means the consumer discards the buffer.
`timescale 1ns / 1ps

module ber_tlv_stream_decoder_core
   import btlv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // tag_class, is_constructed, tag_number, tag_raw,
                                    // value_length, value_byte, element_end, zero pad
   output logic        rsp_tlast,   // last_result
   output logic [1:0]  rsp_tuser    // kind
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       advance;
   logic       pop;
   logic [1:0] fill;
   logic       head_valid;
   step_type   step;
   result_type head;

   assign advance     = in_valid_ff && ({1'b0, fill} + {1'b0, step.count} <= 3'd2);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   btlv_parse u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data_byte  (in_byte_ff),
      .buffer_end (in_end_ff),
      .step       (step)
   );

   assign pop = rsp_tvalid && rsp_tready;

   btlv_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .step       (step),
      .pop        (pop),
      .fill       (fill),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {5'd0, head.element_end, head.value_byte, head.value_length,
                        head.tag_raw, head.tag_number, head.is_constructed,
                        head.tag_class};
   assign rsp_tlast  = head.last_result;
   assign rsp_tuser  = head.kind;

endmodule

// ===== sim/tb_ber_tlv_stream_decoder_core.sv =====
// Testbench for ber_tlv_stream_decoder_core: feeds BER-TLV buffers byte by byte and
// checks every result word against a built-in decoder model kept in a scoreboard class.
// Depends on btlv_pkg and the decoder RTL; directed buffers first, then random ones.
`timescale 1ns / 1ps

module tb_ber_tlv_stream_decoder_core;
   import btlv_pkg::*;

   class tlv_decode_tracker;
      result_type  pending_results[$];
      result_type  step_results[$];
      int          failures;
      phase_type   phase;
      logic [1:0]  held_class;
      logic        held_constructed;
      logic [14:0] held_tag_number;
      logic [23:0] held_tag_raw;
      logic [2:0]  length_bytes_left;
      logic [31:0] held_length;
      logic [31:0] value_bytes_left;
      logic        all_padding;

      function new();
         failures = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase             = PH_TAG1;
         held_class        = '0;
         held_constructed  = 1'b0;
         held_tag_number   = '0;
         held_tag_raw      = '0;
         length_bytes_left = '0;
         held_length       = '0;
         value_bytes_left  = '0;
         all_padding       = 1'b1;
      endfunction

      function result_type make_result(kind_type k, logic [7:0] vb, logic ee, bit carry);
         result_type r;
         r = '0;
         r.kind = k;
         if (carry) begin
            r.tag_class      = held_class;
            r.is_constructed = held_constructed;
            r.tag_number     = held_tag_number;
            r.tag_raw        = held_tag_raw;
            r.value_length   = held_length;
         end
         r.value_byte  = vb;
         r.element_end = ee;
         return r;
      endfunction

      function void close_header();
         logic empty;
         empty = (held_length == 0);
         step_results.push_back(make_result(KIND_HEADER, 8'h00, empty, 1'b1));
         if (empty) begin
            phase = PH_TAG1;
         end else begin
            value_bytes_left = held_length;
            phase = PH_VALUE;
         end
      endfunction

      function void take_byte(logic [7:0] b, logic ends);
         logic       is_ff;
         logic [6:0] nb;
         kind_type   fin;
         step_results.delete();
         is_ff = (b == PAD_BYTE);
         if (phase != PH_TAG1 && phase != PH_VALUE)
            all_padding = all_padding & is_ff;
         case (phase)
            PH_TAG1: begin
               all_padding      = is_ff;
               held_class       = b[7:6];
               held_constructed = b[5];
               held_tag_raw     = {16'd0, b};
               held_length      = '0;
               if ((b & TAG_LONG_MASK) == TAG_LONG_MASK) begin
                  held_tag_number = '0;
                  phase = PH_TAG2;
               end else begin
                  held_tag_number = {10'd0, b[4:0]};
                  phase = PH_LEN1;
               end
            end
            PH_TAG2: begin
               held_tag_raw    = {held_tag_raw[15:0], b};
               held_tag_number = {8'd0, b[6:0]};
               phase = b[7] ? PH_TAG3 : PH_LEN1;
            end
            PH_TAG3: begin
               held_tag_raw    = {held_tag_raw[15:0], b};
               held_tag_number = {held_tag_number[6:0], b};
               phase = PH_LEN1;
            end
            PH_LEN1: begin
               if (!b[7]) begin
                  held_length = {24'd0, b};
                  close_header();
               end else begin
                  nb = b[6:0];
                  if (nb == 0 || nb > LEN_BYTES_MAX) begin
                     phase = PH_SKIP;
                  end else begin
                     length_bytes_left = nb[2:0];
                     held_length = '0;
                     phase = PH_LENX;
                  end
               end
            end
            PH_LENX: begin
               held_length = {held_length[23:0], b};
               if (length_bytes_left > 0)
                  length_bytes_left = length_bytes_left - 1;
               if (length_bytes_left == 0)
                  close_header();
            end
            PH_VALUE: begin
               step_results.push_back(make_result(KIND_VALUE, b, value_bytes_left <= 1, 1'b1));
               if (value_bytes_left > 0)
                  value_bytes_left = value_bytes_left - 1;
               if (value_bytes_left == 0)
                  phase = PH_TAG1;
            end
            default: begin
               phase = PH_SKIP;
            end
         endcase
         if (ends) begin
            if (phase == PH_TAG1)
               fin = KIND_CLEAN;
            else if (phase == PH_VALUE)
               fin = KIND_ERROR;
            else
               fin = all_padding ? KIND_CLEAN : KIND_ERROR;
            step_results.push_back(make_result(fin, 8'h00, 1'b0, 1'b0));
            clear_state();
         end
         if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_result = 1'b1;
         foreach (step_results[i])
            pending_results.push_back(step_results[i]);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void match_result(logic [87:0] data, logic lst, logic [1:0] knd);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: kind %0d data %0h", knd, data);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         check_field("kind", want.kind, knd);
         check_field("tag_class", want.tag_class, data[1:0]);
         check_field("is_constructed", want.is_constructed, data[2]);
         check_field("tag_number", want.tag_number, data[17:3]);
         check_field("tag_raw", want.tag_raw, data[41:18]);
         check_field("value_length", want.value_length, data[73:42]);
         check_field("value_byte", want.value_byte, data[81:74]);
         check_field("element_end", want.element_end, data[82]);
         check_field("last_result", want.last_result, lst);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte
   logic        req_tlast = 1'b0;    // buffer_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;           // tag_class, is_constructed, tag_number, tag_raw,
                                     // value_length, value_byte, element_end, zero pad
   logic        rsp_tlast;           // last_result
   logic [1:0]  rsp_tuser;           // kind

   tlv_decode_tracker board;
   logic [7:0]        frame_bytes[$];
   int                sent_bytes = 0;
   bit                quiet = 1'b0;
   bit                hold_long_req = 1'b0;

   ber_tlv_stream_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample at the falling edge: values here are the ones the next rising edge sees
   always @(negedge clock) begin
      if (!reset && board != null) begin
         if (req_tvalid && req_tready)
            board.take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.match_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      int run;
      int gap;
      @(posedge clock);
      forever begin
         if (hold_long_req) begin
            hold_long_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         run = quiet ? 20 : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [7:0] b, logic l);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) begin
         send_word(frame_bytes[i], i == frame_bytes.size() - 1);
         sent_bytes++;
      end
      frame_bytes.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (board.pending_results.size() != 0);
   endtask

   function automatic void add_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         frame_bytes.push_back({2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                5'($urandom_range(0, 30))});
      end else begin
         frame_bytes.push_back({2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 5'h1f});
         if (r < 80) begin
            frame_bytes.push_back(8'($urandom_range(0, 127)));
         end else begin
            frame_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
            frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   function automatic void add_length(logic [31:0] len);
      int minb;
      int nb;
      if (len < 128 && $urandom_range(0, 3) != 0) begin
         frame_bytes.push_back(len[7:0]);
      end else begin
         minb = (len > 32'hffffff) ? 4 : (len > 32'hffff) ? 3 : (len > 32'hff) ? 2 : 1;
         nb = $urandom_range(minb, LEN_BYTES_MAX);
         frame_bytes.push_back(8'h80 | 8'(nb));
         for (int i = nb - 1; i >= 0; i--)
            frame_bytes.push_back(len[8 * i +: 8]);
      end
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 72)
         return $urandom_range(0, 6);
      if (r < 96)
         return $urandom_range(7, 20);
      if (r < 98)
         return 127;
      return $urandom_range(100, 160);
   endfunction

   function automatic void add_element(int len);
      add_tag();
      add_length(len);
      repeat (len)
         frame_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void build_random_frame();
      int r;
      int start;
      int cut;
      r = $urandom_range(0, 99);
      if (r < 90) begin
         repeat ($urandom_range(0, 2))
            add_element(pick_length());
      end
      if (r < 60) begin
         add_element(pick_length());
      end else if (r < 70) begin
         add_element(pick_length());
         repeat ($urandom_range(1, 5))
            frame_bytes.push_back(PAD_BYTE);
      end else if (r < 80) begin
         // cut the last element inside its header or its value
         start = frame_bytes.size();
         add_element(pick_length());
         cut = $urandom_range(start + 1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut)
            void'(frame_bytes.pop_back());
      end else if (r < 85) begin
         add_tag();
         add_length($urandom());
         repeat ($urandom_range(0, 4))
            frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 90) begin
         add_tag();
         frame_bytes.push_back($urandom_range(0, 1) ? 8'h80 : 8'($urandom_range(8'h85, 8'hff)));
         repeat ($urandom_range(0, 3))
            frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8))
            frame_bytes.push_back(($urandom_range(0, 2) == 0) ? PAD_BYTE :
                                  8'($urandom_range(0, 255)));
      end
   endfunction

   initial begin
      bit did_hold;
      bit did_drain;
      did_hold  = 1'b0;
      did_drain = 1'b0;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty element ending the buffer
      frame_bytes = '{8'h00, 8'h00};
      send_frame();
      // three-byte tag, one-byte long form, single value byte
      frame_bytes = '{8'hdf, 8'hff, 8'h7f, 8'h81, 8'h01, 8'haa};
      send_frame();
      // length 0x7f, value cut short
      frame_bytes = '{8'h3f, 8'h05, 8'h7f, 8'h01, 8'h02};
      send_frame();
      // indefinite length form, skip to end
      frame_bytes = '{8'h01, 8'h80, 8'h11};
      send_frame();
      // padding only
      frame_bytes = '{8'hff, 8'hff, 8'hff};
      send_frame();
      // long form wider than supported
      frame_bytes = '{8'h02, 8'h85};
      send_frame();
      // four-byte length of zero
      frame_bytes = '{8'h04, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();

      while (sent_bytes < 1550) begin
         quiet = (sent_bytes >= 400 && sent_bytes < 520) ||
                 (sent_bytes >= 1100 && sent_bytes < 1200);
         if (!did_hold && sent_bytes >= 400) begin
            hold_long_req = 1'b1;
            did_hold = 1'b1;
         end
         if (!did_drain && sent_bytes >= 800) begin
            wait_drained();
            did_drain = 1'b1;
         end
         build_random_frame();
         send_frame();
      end
      quiet = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
